### hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### hdl/rgbac_pkg.sv
// Types and constants for the RGBA convolution core.
// No dependencies.
`timescale 1ns / 1ps
package rgbac_pkg;
  // store geometry; field widths below are sized for these
  localparam int MAX_KERNEL_SIDE = 16;
  localparam int MAX_IMAGE_SIDE  = 256;
  // coefficient and divisor share this scale, so it cancels in the divide
  localparam int COEFF_FRAC_BITS = 8;

  typedef enum logic [1:0] {
    ACT_COEFF = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_REQ   = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  localparam logic [2:0] REG_KW   = 3'd0;
  localparam logic [2:0] REG_KH   = 3'd1;
  localparam logic [2:0] REG_IW   = 3'd2;
  localparam logic [2:0] REG_IH   = 3'd3;
  localparam logic [2:0] REG_EXT  = 3'd4;
  localparam logic [2:0] REG_NORM = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  tap_column;
    logic [3:0]  tap_row;
    logic signed [15:0] coefficient;
    logic [7:0]  source_column;
    logic [7:0]  source_row;
    logic [31:0] source_pixel;
    logic [8:0]  target_column;
    logic [8:0]  target_row;
  } in_item_t;

  typedef struct packed {
    logic [8:0] out_column;
    logic [8:0] out_row;
    logic [7:0] channel_zero;
    logic [7:0] channel_one;
    logic [7:0] channel_two;
    logic [7:0] channel_three;
  } out_item_t;

  // accumulator: 8b pixel * 16b coeff * 256 taps needs 32 bits signed; AccW gives 34
  localparam int AccW = 34;
  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    logic start;
    logic dividend_neg;
    logic [AccW-1:0] dividend_mag;
    logic [AccW-1:0] divisor_mag;
  } div_req_t;
endpackage

### hdl/rgbac_div.sv
// Sequential restoring divider, one quotient bit per cycle, saturated to 8 bits.
// Depends on rgbac_pkg.
`timescale 1ns / 1ps
module rgbac_div import rgbac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  div_req_t   req_i,
  output logic       done_o,
  output logic [7:0] q_o
);
  localparam int CntW = $clog2(AccW + 1);
  logic [AccW-1:0] rem_q, rem_d, quo_q, quo_d, dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q, ovf_q;
  logic [AccW:0]   trial;
  logic [AccW-1:0] shifted;

  always_comb begin
    shifted = {rem_q[AccW-2:0], quo_q[AccW-1]};
    trial   = {1'b0, shifted} - {1'b0, dsr_q};
    quo_d   = {quo_q[AccW-2:0], ~trial[AccW]};
    rem_d   = trial[AccW] ? shifted : trial[AccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        rem_q <= '0;
        quo_q <= req_i.dividend_mag;
        dsr_q <= req_i.divisor_mag;
        ovf_q <= req_i.dividend_neg;
        cnt_q <= CntW'(AccW);
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (dsr_q == '0) q_o = 8'hFF;
    else if (ovf_q) q_o = 8'h00;
    else if (quo_q[AccW-1:8] != '0) q_o = 8'hFF;
    else q_o = quo_q[7:0];
  end
endmodule

### hdl/rgba_2d_convolution_core.sv
// RGBA 2D convolution core: kernel and frame stores with a tap sequencer.
// Depends on rgbac_pkg, rgbac_div and assert_macros.svh.
// Coefficient and pixel writes never raise busy. A request holds busy through kw*kh tap reads
// (one frame store read per cycle), the pipeline drain, a pass of the shared divider for each
// of the four channels and the output state; the strobe comes in the next cycle, as busy falls.
// Reset sets registers to 3,3,256,256,0,0; the stores are not cleared. No output stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgba_2d_convolution_core import rgbac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_i,
  output logic        out_valid_o,
  output out_item_t   out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int KsW = $clog2(MAX_KERNEL_SIDE);
  localparam int IsW = $clog2(MAX_IMAGE_SIDE);
  localparam int KsL = KsW > 0 ? KsW : 1;

  typedef enum logic [2:0] {S_IDLE, S_TAP, S_DRAIN, S_DIV, S_WAIT, S_OUT} state_e;

  logic [4:0]  kw_q, kh_q;
  logic [8:0]  iw_q, ih_q;
  logic        ext_q;
  logic [15:0] norm_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q <= 5'd3; kh_q <= 5'd3; iw_q <= 9'd256; ih_q <= 9'd256;
      ext_q <= 1'b0; norm_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KW:   kw_q <= cfg_data_i[4:0];
        REG_KH:   kh_q <= cfg_data_i[4:0];
        REG_IW:   iw_q <= cfg_data_i[8:0];
        REG_IH:   ih_q <= cfg_data_i[8:0];
        REG_EXT:  ext_q <= cfg_data_i[0];
        REG_NORM: norm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes
  function automatic logic [12:0] lim(input logic [8:0] v, input int mx);
    logic [12:0] r;
    r = 13'(v);
    if (v == '0) r = 13'd1;
    else if (int'(v) > mx) r = 13'(mx);
    return r;
  endfunction

  logic [12:0] kw_e, kh_e, iw_e, ih_e;
  assign kw_e = lim({4'd0, kw_q}, MAX_KERNEL_SIDE);
  assign kh_e = lim({4'd0, kh_q}, MAX_KERNEL_SIDE);
  assign iw_e = lim(iw_q, MAX_IMAGE_SIDE);
  assign ih_e = lim(ih_q, MAX_IMAGE_SIDE);

  // memories
  logic [15:0] kmem [MAX_KERNEL_SIDE*MAX_KERNEL_SIDE];
  logic [31:0] fmem [MAX_IMAGE_SIDE*MAX_IMAGE_SIDE];
  logic [15:0] krd_q;
  logic [31:0] frd_q;
  logic [2*KsL-1:0] kaddr;
  logic [2*IsW-1:0] faddr;
  logic kwe, fwe;
  logic [2*KsL-1:0] kwa;
  logic [2*IsW-1:0] fwa;

  always_ff @(posedge clk_i) begin
    if (kwe) kmem[kwa] <= in_i.coefficient;
    krd_q <= kmem[kaddr];
  end
  always_ff @(posedge clk_i) begin
    if (fwe) fmem[fwa] <= in_i.source_pixel;
    frd_q <= fmem[faddr];
  end

  state_e      st_q;
  logic [6:0]  kx_q, ky_q;
  logic [8:0]  tx_q, ty_q;
  logic        v1_q, v2_q, hit1_q, hit2_q;
  logic signed [15:0] k2_q;
  logic [31:0] f2_q;
  acc_t        acc_q [4];
  acc_t        csum_q;
  logic [1:0]  ch_q;
  logic [7:0]  res_q [4];
  div_req_t    dreq;
  logic        ddone;
  logic [7:0]  dq;

  assign busy = (st_q != S_IDLE);
  assign kwe = start && !busy && in_i.action == ACT_COEFF &&
               int'(in_i.tap_column) < MAX_KERNEL_SIDE && int'(in_i.tap_row) < MAX_KERNEL_SIDE;
  assign fwe = start && !busy && in_i.action == ACT_PIXEL &&
               int'(in_i.source_column) < MAX_IMAGE_SIDE &&
               int'(in_i.source_row) < MAX_IMAGE_SIDE;
  assign kwa = (2*KsL)'(int'(in_i.tap_row) * MAX_KERNEL_SIDE + int'(in_i.tap_column));
  assign fwa = (2*IsW)'(int'(in_i.source_row) * MAX_IMAGE_SIDE + int'(in_i.source_column));

  // tap address generation
  logic signed [13:0] sx, sy;
  logic hit;
  always_comb begin
    sx = $signed({5'd0, tx_q}) + $signed({7'd0, kx_q}) - $signed({1'b0, kw_e});
    sy = $signed({5'd0, ty_q}) + $signed({7'd0, ky_q}) - $signed({1'b0, kh_e});
    hit = 1'b1;
    if (ext_q) begin
      if (sx < 0) sx = '0;
      if (sx > $signed({1'b0, iw_e}) - 14'sd1) sx = $signed({1'b0, iw_e}) - 14'sd1;
      if (sy < 0) sy = '0;
      if (sy > $signed({1'b0, ih_e}) - 14'sd1) sy = $signed({1'b0, ih_e}) - 14'sd1;
    end else if (sx < 0 || sx >= $signed({1'b0, iw_e}) ||
                 sy < 0 || sy >= $signed({1'b0, ih_e})) begin
      hit = 1'b0;
    end
    kaddr = (2*KsL)'(32'(ky_q) * MAX_KERNEL_SIDE + 32'(kx_q));
    faddr = hit ? (2*IsW)'(32'(sy) * MAX_IMAGE_SIDE + 32'(sx)) : '0;
  end

  logic tap_last;
  assign tap_last = (13'(kx_q) == kw_e - 13'd1) && (13'(ky_q) == kh_e - 13'd1);

  acc_t divsr;
  assign divsr = (norm_q != '0) ? acc_t'({1'b0, norm_q}) : csum_q;

  always_comb begin
    acc_t a, d;
    a = acc_q[ch_q];
    d = divsr;
    dreq.start = (st_q == S_DIV);
    // sign mismatch or zero sum gives 0 (a zero divisor still gives 255): flagged as negative
    dreq.dividend_neg = (a == '0) || (a[AccW-1] != d[AccW-1]);
    dreq.dividend_mag = a[AccW-1] ? AccW'(-a) : AccW'(a);
    dreq.divisor_mag  = d[AccW-1] ? AccW'(-d) : AccW'(d);
  end

  rgbac_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .q_o(dq));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; v1_q <= 1'b0; v2_q <= 1'b0; out_valid_o <= 1'b0;
      kx_q <= '0; ky_q <= '0; ch_q <= '0;
    end else begin
      out_valid_o <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= v1_q;
      hit2_q <= hit1_q;
      k2_q <= krd_q;
      case (st_q)
        S_IDLE: if (start && in_i.action == ACT_REQ) begin
          tx_q <= in_i.target_column; ty_q <= in_i.target_row;
          kx_q <= '0; ky_q <= '0;
          for (int c = 0; c < 4; c++) acc_q[c] <= '0;
          csum_q <= '0;
          st_q <= S_TAP;
        end
        S_TAP: begin
          v1_q <= 1'b1; hit1_q <= hit;
          if (tap_last) st_q <= S_DRAIN;
          else if (13'(kx_q) == kw_e - 13'd1) begin
            kx_q <= '0; ky_q <= ky_q + 7'd1;
          end else kx_q <= kx_q + 7'd1;
        end
        S_DRAIN: if (!v1_q && !v2_q) begin
          ch_q <= '0; st_q <= S_DIV;
        end
        S_DIV: st_q <= S_WAIT;
        S_WAIT: if (ddone) begin
          res_q[ch_q] <= dq;
          ch_q <= ch_q + 2'd1;
          st_q <= (ch_q == 2'd3) ? S_OUT : S_DIV;
        end
        S_OUT: begin
          out_valid_o <= 1'b1; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
      // stage 2: accumulate (krd_q / frd_q are the registered reads)
      if (v2_q) begin
        csum_q <= csum_q + acc_t'(k2_q);
        if (hit2_q)
          for (int c = 0; c < 4; c++)
            acc_q[c] <= acc_q[c] +
                        acc_t'($signed({1'b0, f2_q[8*c +: 8]})) * acc_t'(k2_q);
      end
    end
  end

  always_ff @(posedge clk_i) f2_q <= frd_q;

  assign out_o.out_column    = tx_q;
  assign out_o.out_row       = ty_q;
  assign out_o.channel_zero  = res_q[0];
  assign out_o.channel_one   = res_q[1];
  assign out_o.channel_two   = res_q[2];
  assign out_o.channel_three = res_q[3];

  `ASSERT_IMPL(a_out_idle, clk_i, rst_ni, out_valid_o, st_q == S_IDLE)
  `ASSERT_NEXT(a_req_busy, clk_i, rst_ni, start && !busy && in_i.action == ACT_REQ, busy)
  `ASSERT_IMPL(a_no_acc_idle, clk_i, rst_ni, st_q == S_IDLE, !v1_q)
endmodule

### bench/rgba_2d_convolution_core_tb.sv
// Self-checking bench for rgba_2d_convolution_core: loads kernels and frame pixels,
// requests filtered pixels and scores each result against an in-bench filter model.
// Depends on rgbac_pkg and the core RTL.
`timescale 1ns / 1ps
module rgba_2d_convolution_core_tb;
  import rgbac_pkg::*;

  localparam int KSIDE = 16;
  localparam int ISIDE = 256;
  localparam int STALL_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_i = '0;
  logic        out_valid_o;
  out_item_t   out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = REG_KW;
  logic [15:0] cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  rgba_2d_convolution_core u_dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .out_valid_o, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // shadow state
  logic [15:0] kern_mem [KSIDE*KSIDE];
  logic [31:0] frame_mem [ISIDE*ISIDE];
  bit          frame_set [ISIDE*ISIDE];
  logic [4:0]  kw_reg = 5'd3, kh_reg = 5'd3;
  logic [8:0]  iw_reg = 9'd256, ih_reg = 9'd256;
  logic        ext_reg = 1'b0;
  logic [15:0] norm_reg = '0;

  out_item_t pending_pixels [$];
  int  err_cnt = 0, req_cnt = 0, pix_cnt = 0, cfg_cnt = 0;
  bit  start_hi = 0, cfg_hi = 0, gaps_on = 1;
  int  stall_cnt = 0;

  function automatic int side_of(int v, int mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  // 1 if every frame entry the request would read has been written
  function automatic bit taps_written(int x, int y);
    int kw, kh, iw, ih, sx, sy;
    kw = side_of(int'(kw_reg), KSIDE); kh = side_of(int'(kh_reg), KSIDE);
    iw = side_of(int'(iw_reg), ISIDE); ih = side_of(int'(ih_reg), ISIDE);
    for (int ky = 0; ky < kh; ky++)
      for (int kx = 0; kx < kw; kx++) begin
        sx = x + kx - kw; sy = y + ky - kh;
        if (ext_reg) begin
          if (sx < 0) sx = 0;
          if (sx > iw - 1) sx = iw - 1;
          if (sy < 0) sy = 0;
          if (sy > ih - 1) sy = ih - 1;
        end else if (sx < 0 || sx >= iw || sy < 0 || sy >= ih) continue;
        if (!frame_set[sy*ISIDE+sx]) return 0;
      end
    return 1;
  endfunction

  function automatic logic [7:0] scale_channel(longint sum, longint dv);
    longint q;
    if (dv == 0) return 8'd255;
    if (sum == 0 || ((sum < 0) != (dv < 0))) return 8'd0;
    q = (sum < 0 ? -sum : sum) / (dv < 0 ? -dv : dv);
    return q > 255 ? 8'd255 : q[7:0];
  endfunction

  function automatic out_item_t filter_pixel(int x, int y);
    int kw, kh, iw, ih, sx, sy;
    longint acc [4];
    longint csum, k, dv;
    logic [31:0] px;
    out_item_t r;
    kw = side_of(int'(kw_reg), KSIDE); kh = side_of(int'(kh_reg), KSIDE);
    iw = side_of(int'(iw_reg), ISIDE); ih = side_of(int'(ih_reg), ISIDE);
    csum = 0;
    for (int c = 0; c < 4; c++) acc[c] = 0;
    for (int ky = 0; ky < kh; ky++)
      for (int kx = 0; kx < kw; kx++) begin
        sx = x + kx - kw; sy = y + ky - kh;
        k = longint'($signed(kern_mem[ky*KSIDE+kx]));
        csum += k;
        if (ext_reg) begin
          if (sx < 0) sx = 0;
          if (sx > iw - 1) sx = iw - 1;
          if (sy < 0) sy = 0;
          if (sy > ih - 1) sy = ih - 1;
        end else if (sx < 0 || sx >= iw || sy < 0 || sy >= ih) continue;
        px = frame_mem[sy*ISIDE+sx];
        for (int c = 0; c < 4; c++) acc[c] += longint'({24'd0, px[8*c +: 8]}) * k;
      end
    dv = (norm_reg != 0) ? longint'({48'd0, norm_reg}) : csum;
    r.out_column    = x[8:0];
    r.out_row       = y[8:0];
    r.channel_zero  = scale_channel(acc[0], dv);
    r.channel_one   = scale_channel(acc[1], dv);
    r.channel_two   = scale_channel(acc[2], dv);
    r.channel_three = scale_channel(acc[3], dv);
    return r;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.action        = action_e'($urandom_range(0, 3));
    it.tap_column    = 4'($urandom); it.tap_row = 4'($urandom);
    it.coefficient   = 16'($urandom);
    it.source_column = 8'($urandom); it.source_row = 8'($urandom);
    it.source_pixel  = $urandom;
    it.target_column = 9'($urandom_range(0, 271));
    it.target_row    = 9'($urandom_range(0, 271));
    return it;
  endfunction

  // send one beat; model update happens at acceptance
  task automatic send_item(in_item_t it);
    if (cfg_hi) begin cfg_valid_i <= 1'b0; cfg_hi = 0; end
    in_i <= it;
    if (!start_hi) begin start <= 1'b1; start_hi = 1; end
    do @(posedge clk_i); while (busy);
    case (action_e'(it.action))
      ACT_COEFF: kern_mem[it.tap_row*KSIDE+it.tap_column] = it.coefficient;
      ACT_PIXEL: begin
        frame_mem[it.source_row*ISIDE+it.source_column] = it.source_pixel;
        frame_set[it.source_row*ISIDE+it.source_column] = 1;
      end
      ACT_REQ: begin
        pending_pixels.push_back(filter_pixel(int'(it.target_column),
                                              int'(it.target_row)));
        req_cnt++;
      end
      default: ;
    endcase
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0; start_hi = 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic load_coeff(int c, int r, logic [15:0] v);
    in_item_t it = noise_item();
    it.action = ACT_COEFF; it.tap_column = 4'(c); it.tap_row = 4'(r); it.coefficient = v;
    send_item(it);
  endtask

  task automatic load_pixel(int c, int r, logic [31:0] v);
    in_item_t it = noise_item();
    it.action = ACT_PIXEL; it.source_column = 8'(c); it.source_row = 8'(r);
    it.source_pixel = v;
    send_item(it);
  endtask

  task automatic request(int x, int y);
    in_item_t it = noise_item();
    it.action = ACT_REQ; it.target_column = 9'(x); it.target_row = 9'(y);
    send_item(it);
  endtask

  // random target whose taps only touch written pixels; (0,0) always qualifies
  task automatic request_random();
    int x, y;
    for (int t = 0; t < 30; t++) begin
      if ($urandom_range(0, 1)) begin
        x = $urandom_range(0, 271); y = $urandom_range(0, 271);
      end else begin
        x = $urandom_range(0, 20); y = $urandom_range(0, 20);
      end
      if (taps_written(x, y)) begin request(x, y); return; end
    end
    request(0, 0);
  endtask

  task automatic drain();
    if (start_hi) begin start <= 1'b0; start_hi = 0; end
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index_i <= idx; cfg_data_i <= val;
    if (!cfg_hi) begin cfg_valid_i <= 1'b1; cfg_hi = 1; end
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_cnt++;
    case (idx)
      REG_KW:   kw_reg = val[4:0];
      REG_KH:   kh_reg = val[4:0];
      REG_IW:   iw_reg = val[8:0];
      REG_IH:   ih_reg = val[8:0];
      REG_EXT:  ext_reg = val[0];
      REG_NORM: norm_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_filter(int kw, int kh, int iw, int ih, int ext, int nrm);
    drain();
    set_reg(REG_KW, 16'(kw)); set_reg(REG_KH, 16'(kh));
    set_reg(REG_IW, 16'(iw)); set_reg(REG_IH, 16'(ih));
    set_reg(REG_EXT, 16'(ext)); set_reg(REG_NORM, 16'(nrm));
    if (cfg_hi) begin cfg_valid_i <= 1'b0; cfg_hi = 0; end
  endtask

  task automatic rand_coeff(output logic [15:0] v);
    if ($urandom_range(0, 4) == 0) v = 16'($urandom);
    else v = 16'($urandom_range(0, 700) - 150);
  endtask

  // whole kernel store, an 8x8 corner of the frame and a few edge pixels,
  // so later reads are defined; then one random request
  task automatic test_store_fill();
    logic [15:0] v;
    for (int r = 0; r < KSIDE; r++)
      for (int c = 0; c < KSIDE; c++) begin
        rand_coeff(v); load_coeff(c, r, v);
      end
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) load_pixel(c, r, $urandom);
    load_pixel(0, 0, 32'h0000_0000);
    load_pixel(1, 0, 32'hFFFF_FFFF);
    load_pixel(255, 255, 32'hFFFF_FFFF);
    load_pixel(0, 255, $urandom);
    request_random();
  endtask

  task automatic test_directed();
    in_item_t it;
    set_filter(1, 1, 8, 8, 0, 256);
    load_coeff(0, 0, 16'sd256);            // identity tap
    request(2, 1);
    request(1, 1);
    load_coeff(0, 0, 16'h7FFF);            // saturates high
    request(2, 1);
    load_coeff(0, 0, 16'h8000);            // negative quotient
    request(2, 1);
    set_filter(1, 1, 8, 8, 0, 0);
    load_coeff(0, 0, 16'd0);               // zero divisor
    request(2, 1);
    it = noise_item(); it.action = ACT_NONE; send_item(it);
    set_filter(0, 31, 0, 511, 1, 65535);   // size zero and oversize
    request(271, 271);
    request(0, 0);
    set_filter(31, 0, 511, 0, 1, 1);
    request(0, 271);
    set_filter(16, 16, 256, 256, 0, 0);
    request(271, 271);
    request(8, 8);
    set_filter(3, 3, 4, 4, 0, 300);
    request(271, 0);
  endtask

  task automatic test_random(int phases, int per_phase);
    logic [15:0] v;
    int sel, nrm;
    for (int p = 0; p < phases; p++) begin
      gaps_on = (p < phases - 1);
      case ($urandom_range(0, 3))
        0: nrm = 0;
        1: nrm = $urandom_range(1, 2000);
        2: nrm = 65535;
        default: nrm = $urandom;
      endcase
      if (p == 0) set_filter(16, 16, 256, 256, 1, nrm);
      else if (p == 1) set_filter(1, 1, 1, 1, 0, nrm);
      else set_filter($urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                : $urandom_range(1, 16),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                : $urandom_range(1, 16),
                      $urandom_range(0, 1), nrm);
      for (int i = 0; i < per_phase; i++) begin
        if (p == 2 && i == per_phase / 2) drain();
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
          rand_coeff(v); load_coeff($urandom, $urandom, v);
        end else if (sel < 55) begin
          if ($urandom_range(0, 3) == 0) load_pixel($urandom, $urandom, $urandom);
          else load_pixel($urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        end else if (sel < 95) request_random();
        else begin
          in_item_t it = noise_item();
          it.action = ACT_NONE; send_item(it);
        end
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      out_item_t e;
      pix_cnt++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result at column %0d row %0d", out_o.out_column, out_o.out_row);
        err_cnt++;
      end else begin
        e = pending_pixels.pop_front();
        if (out_o.out_column !== e.out_column) begin
          $error("out_column exp %0d got %0d", e.out_column, out_o.out_column); err_cnt++;
        end
        if (out_o.out_row !== e.out_row) begin
          $error("out_row exp %0d got %0d", e.out_row, out_o.out_row); err_cnt++;
        end
        if (out_o.channel_zero !== e.channel_zero) begin
          $error("channel_zero exp %0d got %0d", e.channel_zero, out_o.channel_zero);
          err_cnt++;
        end
        if (out_o.channel_one !== e.channel_one) begin
          $error("channel_one exp %0d got %0d", e.channel_one, out_o.channel_one); err_cnt++;
        end
        if (out_o.channel_two !== e.channel_two) begin
          $error("channel_two exp %0d got %0d", e.channel_two, out_o.channel_two); err_cnt++;
        end
        if (out_o.channel_three !== e.channel_three) begin
          $error("channel_three exp %0d got %0d", e.channel_three, out_o.channel_three);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: cycles without any beat moving
  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || out_valid_o) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("rgba_2d_convolution_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_store_fill();
    test_directed();
    test_random(4, 65);
    drain();
    repeat (20) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      $error("%0d results never arrived", pending_pixels.size());
      err_cnt++;
    end
    $display("covered %0d requests, %0d results, %0d register writes, %0d errors",
             req_cnt, pix_cnt, cfg_cnt, err_cnt);
    if (err_cnt == 0) $display("rgba_2d_convolution_core regression: pass");
    else $display("rgba_2d_convolution_core regression: fail");
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/rgbac_pkg.sv
hdl/rgbac_div.sv
hdl/rgba_2d_convolution_core.sv
bench/rgba_2d_convolution_core_tb.sv
